// File: rtl/npcs_pkg.sv
// Shared types and constants for the nearest palette color search unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W = $clog2(PALETTE_ENTRIES);

    localparam logic [8:0] ENTRIES_9 = 9'(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    localparam logic [7:0] OPAQUE_ALPHA = 8'd255;
    localparam logic [7:0] FIRST_MAP_SLOT_RESET = 8'd17;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic       opaque;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } pal_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } pal_rd_t;

endpackage

`default_nettype wire

// File: rtl/npcs_palette_ram.sv
// Palette store: synchronous RAM of entries with a registered read.
// Per-entry valid flops make never-written entries read as transparent black.
// Depends on npcs_pkg.
`default_nettype none

module npcs_palette_ram
    import npcs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire pal_wr_t wr,
    input  wire pal_rd_t rd,
    output entry_t       rdata
);

    entry_t                     mem [PALETTE_ENTRIES];
    entry_t                     raw_reg;
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    logic                       rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            raw_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? raw_reg : '0;

endmodule

`default_nettype wire

// File: rtl/npcs_scan.sv
// Lookup sequencer: walks the palette one entry per cycle, tracks the best
// L1 match and holds the result in the output register.
// Depends on npcs_pkg.
`default_nettype none

module npcs_scan
    import npcs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [7:0] first_map_slot,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output pal_rd_t         rd,
    input  wire entry_t     rdata,
    output logic            busy,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      pal_index,
    output logic [9:0]      distance,
    output logic            found
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [7:0]       best_idx_reg, best_idx_next;
    logic [9:0]       best_dist_reg, best_dist_next;
    logic             have_reg, have_next;
    logic [7:0]       r_reg, g_reg, b_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_idx_reg;
    logic [9:0]       out_dist_reg;
    logic             out_found_reg;

    logic [7:0] dr, dg, db;
    logic [9:0] l1_sum;
    logic       hit, better, exact, last, load_out, fms_out;

    assign dr     = (rdata.red > r_reg) ? rdata.red - r_reg : r_reg - rdata.red;
    assign dg     = (rdata.green > g_reg) ? rdata.green - g_reg : g_reg - rdata.green;
    assign db     = (rdata.blue > b_reg) ? rdata.blue - b_reg : b_reg - rdata.blue;
    assign l1_sum = {2'b00, dr} + {2'b00, dg} + {2'b00, db};

    assign hit    = (state_reg == ST_SCAN) && pend_reg && rdata.opaque;
    assign better = hit && (!have_reg || (l1_sum < best_dist_reg));
    assign exact  = hit && (l1_sum == 10'd0);
    assign last   = (state_reg == ST_SCAN) && pend_reg && !issue_reg;

    assign fms_out  = {1'b0, first_map_slot} >= ENTRIES_9;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign rd.en   = (state_reg == ST_SCAN) && issue_reg;
    assign rd.addr = idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        have_next      = have_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    best_idx_next  = first_map_slot;
                    best_dist_next = 10'd0;
                    have_next      = 1'b0;
                    idx_next       = first_map_slot[IDX_W-1:0];
                    issue_next     = !fms_out;
                    state_next     = fms_out ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                pend_next = issue_reg;
                if (issue_reg)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (better)
                begin
                    best_idx_next  = 8'(pend_idx_reg);
                    best_dist_next = l1_sum;
                    have_next      = 1'b1;
                end
                // exact match ends the scan; reads still in flight are dropped
                if (exact || last)
                begin
                    state_next = ST_DONE;
                    issue_next = 1'b0;
                    pend_next  = 1'b0;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pend_idx_reg  <= idx_reg;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        have_reg      <= have_next;
        if (start && (state_reg == ST_IDLE))
        begin
            r_reg <= red;
            g_reg <= green;
            b_reg <= blue;
        end
        if (load_out)
        begin
            out_idx_reg   <= best_idx_reg;
            out_dist_reg  <= best_dist_reg;
            out_found_reg <= have_reg;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign pal_index = out_idx_reg;
    assign distance  = out_dist_reg;
    assign found     = out_found_reg;

endmodule

`default_nettype wire

// File: rtl/nearest_palette_color_search_unit.sv
// Lookup: the scan state reads N = 256 - first_map_slot entries, from first_map_slot
// up, one per cycle from the palette RAM; an exact match ends the scan early.
// in_stall holds until the done state loads the result into the output register.
// Writes give no result; a new item is taken while a result waits.
// Reset (async, active low) empties the palette and sets first_map_slot to 17.
// Top level: palette RAM, scan sequencer and the config register; uses npcs_pkg.
`default_nettype none

module nearest_palette_color_search_unit
    import npcs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       op,
    input  wire logic [7:0] slot,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    input  wire logic [7:0] alpha,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      pal_index,
    output logic [9:0]      distance,
    output logic            found
);

    logic [7:0] fms_reg;
    logic       busy;
    logic       in_xfer;
    pal_wr_t    wr;
    pal_rd_t    rd;
    entry_t     rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fms_reg <= FIRST_MAP_SLOT_RESET;
        end
        else if (cfg_we)
        begin
            fms_reg <= cfg_data;
        end
    end

    assign in_stall = busy;
    assign in_xfer  = in_valid && !busy;

    assign wr.en          = in_xfer && (op == OP_WRITE) && ({1'b0, slot} < ENTRIES_9);
    assign wr.addr        = slot[IDX_W-1:0];
    assign wr.data.opaque = (alpha == OPAQUE_ALPHA);
    assign wr.data.red    = red;
    assign wr.data.green  = green;
    assign wr.data.blue   = blue;

    npcs_palette_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    npcs_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (in_xfer && (op == OP_LOOKUP)),
        .first_map_slot (fms_reg),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .rd             (rd),
        .rdata          (rdata),
        .busy           (busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pal_index      (pal_index),
        .distance       (distance),
        .found          (found)
    );

endmodule

`default_nettype wire

// File: rtl/npcs_checker.sv
// Port-level assertions for nearest_palette_color_search_unit, bound to the top.
// Depends on npcs_pkg.
`default_nettype none

module npcs_checker
    import npcs_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       op,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] pal_index,
    input wire logic [9:0] distance,
    input wire logic       found
);

    // no result right out of reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result present after reset");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (distance == 10'd0))
        else $error("nonzero distance on not-found result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(pal_index) && $stable(distance) && $stable(found)))
        else $error("stalled result changed");

    // a lookup transfer always starts a scan and so raises in_stall
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (op == OP_LOOKUP)) |=> in_stall)
        else $error("lookup did not start a scan");

    // a write never creates a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (op == OP_WRITE) && !out_valid) |=> !out_valid)
        else $error("write produced a result");

endmodule

bind nearest_palette_color_search_unit npcs_checker u_npcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pal_index (pal_index),
    .distance  (distance),
    .found     (found)
);

`default_nettype wire
